/* hdl/wmsr_pkg.sv */
// Shared types and constants for the window mean / stddev / RMS block.
package wmsr_pkg;

  localparam int unsigned CountBits  = 11;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned SumBits    = 26;
  localparam int unsigned SqBits     = 41;
  localparam int unsigned OutBits    = 24;

  localparam logic [1:0] ModePush        = 2'd0;
  localparam logic [1:0] ModeReport      = 2'd1;
  localparam logic [1:0] ModeReportClear = 2'd2;

  // Window contents captured at a report.
  typedef struct packed {
    logic [CountBits-1:0]     count;
    logic                     full;
    logic signed [SumBits-1:0] sum;
    logic [SqBits-1:0]        sumsq;
  } snap_t;

endpackage

/* hdl/window_mean_stddev_rms_top.sv */
// Top level of the window mean / standard deviation / RMS accumulator.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   mode_i, sample_i
//  out       output     out_valid_o / out_stall_i count_o, full_res_o, mean_value_o,
//                                                 std_deviation_o, rms_value_o
//  config    input      window_capacity_we_i      window_capacity_i
//
// A push updates the running sums; pushes never stall. A report is queued
// (two entries) and worked in the back end: a 1-bit-per-cycle divider runs
// twice over 57 bits, one multiply, then a 1-bit-per-cycle square root runs
// twice over 24 bits. A report stalls only while the queue is full. Reset
// clears the window and sets the capacity to 1024.
module window_mean_stddev_rms_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic signed [wmsr_pkg::SampleBits-1:0] sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [wmsr_pkg::CountBits-1:0]  count_o,
  output logic                            full_res_o,
  output logic signed [wmsr_pkg::OutBits-1:0] mean_value_o,
  output logic [wmsr_pkg::OutBits-1:0]    std_deviation_o,
  output logic [wmsr_pkg::OutBits-1:0]    rms_value_o,
  input  logic                            window_capacity_we_i,
  input  logic [wmsr_pkg::CountBits-1:0]  window_capacity_i
);
  import wmsr_pkg::*;

  logic  q_full, q_push, q_pop, q_valid;
  snap_t q_wdata, q_rdata;

  wmsr_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .sample_i,
    .window_capacity_we_i, .window_capacity_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  wmsr_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  wmsr_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .count_o, .full_res_o,
    .mean_value_o, .std_deviation_o, .rms_value_o
  );

endmodule

/* hdl/wmsr_front.sv */
// Front end: accepts items, keeps the running sums, queues report snapshots.
module wmsr_front #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic signed [wmsr_pkg::SampleBits-1:0] sample_i,
  input  logic                            window_capacity_we_i,
  input  logic [wmsr_pkg::CountBits-1:0]  window_capacity_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output wmsr_pkg::snap_t                 q_data_o
);
  import wmsr_pkg::*;

  localparam logic [16:0] CapLimit = 17'(CAPACITY);

  logic [CountBits-1:0]     cap_q;
  logic [CountBits-1:0]     count_q, count_d;
  logic signed [SumBits-1:0] sum_q, sum_d;
  logic [SqBits-1:0]        sumsq_q, sumsq_d;
  logic [CountBits-1:0]     eff_cap;
  logic                     is_report;
  logic                     accept;
  logic signed [2*SampleBits-1:0] square;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CountBits'(1);
    end else if ({6'b0, cap_q} > CapLimit) begin
      eff_cap = CountBits'(CAPACITY);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign is_report  = (mode_i == ModeReport) || (mode_i == ModeReportClear);
  // Hold reports while the queue is full; pushes always go through.
  assign in_stall_o = q_full_i && is_report;
  assign accept     = in_valid_i && !in_stall_o;
  assign square     = sample_i * sample_i;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    if (accept) begin
      case (mode_i)
        ModePush: begin
          if (count_q < eff_cap) begin
            count_d = count_q + CountBits'(1);
            sum_d   = sum_q + SumBits'(sample_i);
            sumsq_d = sumsq_q + SqBits'($unsigned(square));
          end
        end
        ModeReportClear: begin
          count_d = '0;
          sum_d   = '0;
          sumsq_d = '0;
        end
        default: ;
      endcase
    end
  end

  assign q_push_o       = accept && is_report;
  assign q_data_o.count = count_q;
  assign q_data_o.full  = (count_q >= eff_cap);
  assign q_data_o.sum   = sum_q;
  assign q_data_o.sumsq = sumsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CountBits'(1024);
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else begin
      if (window_capacity_we_i) begin
        cap_q <= window_capacity_i;
      end
      count_q <= count_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
    end
  end

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({6'b0, count_q} <= CapLimit))
    else $error("sample count above capacity");

endmodule

/* hdl/wmsr_fifo.sv */
// Two-entry queue of report snapshots between front and back.
module wmsr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wmsr_pkg::snap_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output wmsr_pkg::snap_t data_o
);
  import wmsr_pkg::*;

  snap_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

/* hdl/wmsr_back.sv */
// Back end: serial divider, multiplier and square root that turn a snapshot into a result.
module wmsr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  wmsr_pkg::snap_t               q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wmsr_pkg::CountBits-1:0] count_o,
  output logic                          full_res_o,
  output logic signed [wmsr_pkg::OutBits-1:0] mean_value_o,
  output logic [wmsr_pkg::OutBits-1:0]  std_deviation_o,
  output logic [wmsr_pkg::OutBits-1:0]  rms_value_o
);
  import wmsr_pkg::*;

  localparam int unsigned DvdBits = SqBits + 2*FracBits;   // 57
  localparam int unsigned RadBits = 2*OutBits;             // 48

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StVar  = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]               state_q;
  logic                     phase_q;   // divide: mean/mean square; root: stddev/rms
  logic [5:0]               step_q;
  snap_t                    snap_q;
  logic [DvdBits-1:0]       dvd_q;
  logic [CountBits-1:0]     rem_q;
  logic [OutBits-1:0]       amean_q;
  logic signed [OutBits-1:0] mean_q;
  logic [RadBits-1:0]       ms_q, msq_q, rad_q;
  logic [OutBits-1:0]       root_q, sd_q;
  logic [OutBits+1:0]       srem_q;
  logic                     out_valid_q;

  // Divider step
  logic [CountBits:0]   dtry;
  logic                 dge;
  logic [CountBits-1:0] rem_n;
  // Root step
  logic [OutBits+3:0]   strial, stry;
  logic                 sge;
  // Mean correction
  logic [SumBits-1:0]   abs_sum;
  logic [OutBits-1:0]   amean_n;

  assign dtry  = {rem_q, dvd_q[DvdBits-1]};
  assign dge   = dtry >= {1'b0, snap_q.count};
  assign rem_n = dge ? CountBits'(dtry - {1'b0, snap_q.count}) : dtry[CountBits-1:0];

  assign stry   = {srem_q, rad_q[RadBits-1 -: 2]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = stry >= strial;

  assign abs_sum = q_data_i.sum[SumBits-1] ? SumBits'(-q_data_i.sum)
                                           : SumBits'(q_data_i.sum);
  // Floor toward minus infinity: bump the magnitude of a negative inexact quotient.
  assign amean_n = {dvd_q[OutBits-2:0], dge}
                 + OutBits'(snap_q.sum[SumBits-1] && (rem_n != '0));

  assign q_pop_o     = (state_q == StIdle) && q_valid_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            phase_q <= 1'b0;
            step_q  <= 6'(DvdBits - 1);
            state_q <= (q_data_i.count == '0) ? StDone : StDiv;
          end
        end
        StDiv: begin
          if (step_q == '0) begin
            step_q <= 6'(DvdBits - 1);
            if (phase_q) begin
              state_q <= StMul;
            end
            phase_q <= !phase_q;
          end else begin
            step_q <= step_q - 6'd1;
          end
        end
        StMul: state_q <= StVar;
        StVar: begin
          phase_q <= 1'b0;
          step_q  <= 6'(OutBits - 1);
          state_q <= StSqrt;
        end
        StSqrt: begin
          if (step_q == '0) begin
            step_q  <= 6'(OutBits - 1);
            phase_q <= 1'b1;
            if (phase_q) begin
              state_q <= StDone;
            end
          end else begin
            step_q <= step_q - 6'd1;
          end
        end
        StDone: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          snap_q  <= q_data_i;
          dvd_q   <= DvdBits'({abs_sum, {FracBits{1'b0}}});
          rem_q   <= '0;
          amean_q <= '0;
          mean_q  <= '0;
          sd_q    <= '0;
          root_q  <= '0;
        end
      end
      StDiv: begin
        if (step_q == '0) begin
          if (!phase_q) begin
            amean_q <= amean_n;
            mean_q  <= snap_q.sum[SumBits-1] ? OutBits'(-amean_n) : amean_n;
            dvd_q   <= {snap_q.sumsq, {(2*FracBits){1'b0}}};
            rem_q   <= '0;
          end else begin
            ms_q <= RadBits'({dvd_q[DvdBits-2:0], dge});
          end
        end else begin
          dvd_q <= {dvd_q[DvdBits-2:0], dge};
          rem_q <= rem_n;
        end
      end
      StMul: msq_q <= amean_q * amean_q;
      StVar: begin
        rad_q  <= (ms_q > msq_q) ? (ms_q - msq_q) : '0;
        root_q <= '0;
        srem_q <= '0;
      end
      StSqrt: begin
        if (step_q == '0 && !phase_q) begin
          sd_q   <= {root_q[OutBits-2:0], sge};
          rad_q  <= ms_q;
          root_q <= '0;
          srem_q <= '0;
        end else begin
          root_q <= {root_q[OutBits-2:0], sge};
          srem_q <= sge ? (OutBits+2)'(stry - strial) : stry[OutBits+1:0];
          rad_q  <= {rad_q[RadBits-3:0], 2'b00};
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          count_o         <= snap_q.count;
          full_res_o      <= snap_q.full;
          mean_value_o    <= mean_q;
          std_deviation_o <= sd_q;
          rms_value_o     <= root_q;
        end
      end
      default: ;
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (snap_q.count != '0))
    else $error("divide by empty count");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q != StIdle))
    else $error("snapshot taken without starting work");

endmodule

/* test/tb_top.sv */
// Testbench for the window mean / standard deviation / RMS accumulator.
`timescale 1ns / 100ps

module tb_top;
  import wmsr_pkg::*;

  localparam int unsigned Cap = 1024;
  localparam int unsigned MaxCycles = 3000000;
  // Mode 3 is unused by the block and must be ignored.
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [CountBits-1:0]       count;
    logic                       full;
    logic signed [OutBits-1:0]  mean;
    logic [OutBits-1:0]         sd;
    logic [OutBits-1:0]         rms;
  } stats_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] mode_i;
  logic signed [SampleBits-1:0] sample_i;
  logic out_valid_o, out_stall_i;
  logic [CountBits-1:0] count_o;
  logic full_res_o;
  logic signed [OutBits-1:0] mean_value_o;
  logic [OutBits-1:0] std_deviation_o, rms_value_o;
  logic window_capacity_we_i;
  logic [CountBits-1:0] window_capacity_i;

  window_mean_stddev_rms_top #(.CAPACITY(Cap)) u_dut (.*);

  // Predictor state
  logic [CountBits-1:0] win_cap;
  logic [CountBits-1:0] win_count;
  logic signed [SumBits-1:0] win_sum;
  logic [SqBits-1:0] win_sumsq;

  stats_t stats_q[$];
  int errors;
  int unsigned cycles;
  bit out_quiet;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int unsigned eff_cap();
    if (win_cap == 0) return 1;
    if (win_cap > Cap) return Cap;
    return win_cap;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic stats_t window_stats();
    stats_t s;
    longint m, num, c;
    logic [127:0] ms, msq, v;
    logic [63:0] r;
    s = '0;
    c = win_count;
    s.count = win_count;
    s.full = (win_count >= eff_cap());
    if (c != 0) begin
      num = longint'(win_sum) * 256;
      m = num / c;
      if (num % c != 0 && num < 0) m = m - 1;
      if (m > 8388607) s.mean = 24'h7fffff;
      else if (m < -8388608) s.mean = 24'h800000;
      else s.mean = m[23:0];
      ms = ({87'd0, win_sumsq} << 16) / c;
      msq = (m < 0) ? (-m) * (-m) : m * m;
      v = (ms > msq) ? ms - msq : 0;
      r = isqrt(v[63:0]);
      s.sd = (r > 64'hffffff) ? 24'hffffff : r[23:0];
      r = isqrt(ms[63:0]);
      s.rms = (r > 64'hffffff) ? 24'hffffff : r[23:0];
    end
    return s;
  endfunction

  function automatic void predict(logic [1:0] md, logic signed [SampleBits-1:0] smp);
    if (md == ModePush) begin
      if (win_count < eff_cap()) begin
        win_sum = win_sum + SumBits'(smp);
        win_sumsq = win_sumsq + SqBits'(longint'(smp) * longint'(smp));
        win_count = win_count + CountBits'(1);
      end
    end else if (md != ModeUnused) begin
      stats_q.push_back(window_stats());
      if (md == ModeReportClear) begin
        win_count = '0;
        win_sum = '0;
        win_sumsq = '0;
      end
    end
  endfunction

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_q.size() == 0) begin
        $display("%0t unexpected result count %0d", $time, count_o);
        errors++;
      end else begin
        e = stats_q.pop_front();
        if (e.count !== count_o) begin
          $display("%0t count exp %0d got %0d", $time, e.count, count_o); errors++;
        end
        if (e.full !== full_res_o) begin
          $display("%0t full exp %0d got %0d", $time, e.full, full_res_o); errors++;
        end
        if (e.mean !== mean_value_o) begin
          $display("%0t mean exp %0d got %0d", $time, e.mean, mean_value_o); errors++;
        end
        if (e.sd !== std_deviation_o) begin
          $display("%0t stddev exp %0d got %0d", $time, e.sd, std_deviation_o); errors++;
        end
        if (e.rms !== rms_value_o) begin
          $display("%0t rms exp %0d got %0d", $time, e.rms, rms_value_o); errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 10) != 0) : 1'b0;
  end

  task automatic send_item(logic [1:0] md, logic signed [SampleBits-1:0] smp, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(md, smp);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    // idle a while before reconfiguring
    repeat (400) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CountBits-1:0] v);
    drain();
    window_capacity_we_i <= 1'b1;
    window_capacity_i <= v;
    @(negedge clk_i);
    window_capacity_we_i <= 1'b0;
    win_cap = v;
  endtask

  task automatic test_directed();
    send_item(ModeReport, 0, 0);           // empty window
    send_item(ModePush, 16'sh7fff, 0);
    send_item(ModePush, 16'sh8000, 0);
    send_item(ModePush, -16'sd1, 0);
    send_item(ModeReport, 0, 0);
    send_item(ModeUnused, 16'sh1234, 0);
    send_item(ModeReportClear, 0, 0);
    repeat (3) send_item(ModePush, 16'sh8000, 0);
    send_item(ModeReportClear, 0, 1);
    send_item(ModePush, 16'sh5555, 1);
    send_item(ModePush, -16'sh2aab, 1);
    send_item(ModeReport, 0, 1);
  endtask

  task automatic test_capacity();
    set_capacity(0);                        // acts as one
    send_item(ModePush, 16'sd100, 0);
    send_item(ModePush, 16'sd200, 0);
    send_item(ModeReport, 0, 0);
    set_capacity(11'h7ff);                  // clamps to the maximum
    send_item(ModePush, 16'sd5, 0);
    send_item(ModeReport, 0, 0);
    set_capacity(1);                        // lowered below count
    send_item(ModePush, 16'sd7, 0);
    send_item(ModeReportClear, 0, 0);
  endtask

  task automatic test_full_window();
    // fill to maximum capacity with extreme samples
    set_capacity(11'd1024);
    repeat (1030) send_item(ModePush, ($urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff), 0);
    send_item(ModeReportClear, 0, 0);
  endtask

  task automatic test_random();
    int unsigned n, cap_sel;
    logic [CountBits-1:0] caps[4] = '{11'd3, 11'd17, 11'd64, 11'd1};
    n = 0;
    while (n < 150) begin
      if ($urandom_range(0, 40) == 0) begin
        cap_sel = $urandom_range(0, 3);
        set_capacity(caps[cap_sel]);
      end
      if ($urandom_range(0, 120) == 0) drain();
      case ($urandom_range(0, 19))
        0, 1: send_item(ModeReport, SampleBits'($urandom), 1);
        2: send_item(ModeReportClear, SampleBits'($urandom), 1);
        3: send_item(ModeUnused, SampleBits'($urandom), 1);
        default: send_item(ModePush, SampleBits'($urandom), ($urandom_range(0, 3) == 0));
      endcase
      n++;
    end
    set_capacity(11'd1024);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    out_quiet = 1'b0;
    win_cap = 11'd1024;
    win_count = '0;
    win_sum = '0;
    win_sumsq = '0;
    in_valid_i = 1'b0;
    mode_i = ModePush;
    sample_i = '0;
    out_stall_i = 1'b0;
    window_capacity_we_i = 1'b0;
    window_capacity_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_capacity();
    test_full_window();
    test_random();
    out_quiet = 1'b1;
    drain();
    if (errors == 0 && stats_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
